// ===== design/cfb_pkg.sv =====
// Shared types and constants for the closable channel FIFO bank.
// Used by cfb_ctrl and the top level; no dependencies of its own.
`default_nettype none

package cfb_pkg;

   localparam int NUM_CHANNELS  = 8;
   localparam int CHANNEL_DEPTH = 16;
   localparam int WORD_BITS     = 32;

   localparam int CH_BITS    = $clog2(NUM_CHANNELS);
   localparam int PTR_BITS   = $clog2(CHANNEL_DEPTH);
   localparam int CNT_BITS   = $clog2(CHANNEL_DEPTH + 1);
   localparam int ADDR_BITS  = CH_BITS + PTR_BITS;
   localparam int STORE_SIZE = NUM_CHANNELS * CHANNEL_DEPTH;

   typedef enum logic [2:0] {
      OP_OPEN   = 3'd0,
      OP_SEND   = 3'd1,
      OP_RECV   = 3'd2,
      OP_POLL   = 3'd3,
      OP_CLOSE  = 3'd4,
      OP_SELECT = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BLOCK  = 2'd1,
      ST_CLOSED = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      logic [WORD_BITS-1:0] wdata;
      logic                 re;
      logic [ADDR_BITS-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic               pop;
      logic [CH_BITS-1:0] chan;
   } result_type;

   function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] ptr,
                                                  input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS-1:0] nxt;
      nxt = CNT_BITS'(ptr) + CNT_BITS'(1);
      return (nxt >= cap) ? '0 : nxt[PTR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/cfb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module cfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== design/cfb_ctrl.sv =====
// Per-channel ring control: pointers, fill counts, capacities, closed flags.
// Decodes one operation per cycle into a word-store access and a result tag. Uses cfb_pkg.
`default_nettype none

module cfb_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [2:0]                    opcode,
   input  wire logic [2:0]                    channel_id,
   input  wire logic [cfb_pkg::WORD_BITS-1:0] write_value,
   input  wire logic [4:0]                    open_capacity,
   input  wire logic [7:0]                    select_mask,
   output cfb_pkg::mem_req_type               mem_req,
   output cfb_pkg::result_type                result
);

   localparam int NCH = cfb_pkg::NUM_CHANNELS;

   logic [cfb_pkg::PTR_BITS-1:0] rd_ptr_ff [NCH];
   logic [cfb_pkg::PTR_BITS-1:0] rd_ptr_in [NCH];
   logic [cfb_pkg::PTR_BITS-1:0] wr_ptr_ff [NCH];
   logic [cfb_pkg::PTR_BITS-1:0] wr_ptr_in [NCH];
   logic [cfb_pkg::CNT_BITS-1:0] fill_ff   [NCH];
   logic [cfb_pkg::CNT_BITS-1:0] fill_in   [NCH];
   logic [cfb_pkg::CNT_BITS-1:0] cap_ff    [NCH];
   logic [cfb_pkg::CNT_BITS-1:0] cap_in    [NCH];
   logic [NCH-1:0]               closed_ff, closed_in;
   logic [NCH-1:0]               nonempty_ff, nonempty_in;

   logic                         ch_ok;
   logic [cfb_pkg::CH_BITS-1:0]  ch;
   logic [NCH-1:0]               cand;
   logic                         sel_any;
   logic [cfb_pkg::CH_BITS-1:0]  sel_ch;
   logic                         do_pop;
   logic [cfb_pkg::CH_BITS-1:0]  pop_ch;
   logic [cfb_pkg::CNT_BITS-1:0] new_cap;
   cfb_pkg::op_type              op;

   assign op      = cfb_pkg::op_type'(opcode);
   assign ch_ok   = int'(channel_id) < NCH;
   assign ch      = channel_id[cfb_pkg::CH_BITS-1:0];
   assign cand    = select_mask[NCH-1:0] & nonempty_ff;
   assign sel_any = |cand;

   always_comb begin
      sel_ch = '0;
      for (int i = NCH - 1; i >= 0; i--) begin
         if (cand[i]) begin
            sel_ch = cfb_pkg::CH_BITS'(i);
         end
      end
   end

   always_comb begin
      if (open_capacity == '0 || int'(open_capacity) > cfb_pkg::CHANNEL_DEPTH) begin
         new_cap = cfb_pkg::CNT_BITS'(cfb_pkg::CHANNEL_DEPTH);
      end else begin
         new_cap = cfb_pkg::CNT_BITS'(open_capacity);
      end
   end

   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_in       = fill_ff;
      cap_in        = cap_ff;
      closed_in     = closed_ff;
      nonempty_in   = nonempty_ff;
      mem_req       = '0;
      mem_req.wdata = write_value;
      result        = '0;
      result.valid  = accept;
      result.status = cfb_pkg::ST_OK;
      do_pop        = 1'b0;
      pop_ch        = ch;

      if (accept) begin
         unique case (op)
            cfb_pkg::OP_OPEN: begin
               if (ch_ok) begin
                  rd_ptr_in[ch]   = '0;
                  wr_ptr_in[ch]   = '0;
                  fill_in[ch]     = '0;
                  cap_in[ch]      = new_cap;
                  closed_in[ch]   = 1'b0;
                  nonempty_in[ch] = 1'b0;
               end
            end
            cfb_pkg::OP_SEND: begin
               if (!ch_ok || closed_ff[ch]) begin
                  result.status = cfb_pkg::ST_CLOSED;
               end else if (fill_ff[ch] >= cap_ff[ch]) begin
                  result.status = cfb_pkg::ST_BLOCK;
               end else begin
                  mem_req.we      = 1'b1;
                  mem_req.waddr   = {ch, wr_ptr_ff[ch]};
                  wr_ptr_in[ch]   = cfb_pkg::advance(wr_ptr_ff[ch], cap_ff[ch]);
                  fill_in[ch]     = fill_ff[ch] + cfb_pkg::CNT_BITS'(1);
                  nonempty_in[ch] = 1'b1;
               end
            end
            cfb_pkg::OP_RECV: begin
               if (ch_ok && nonempty_ff[ch]) begin
                  do_pop = 1'b1;
               end else if (!ch_ok || closed_ff[ch]) begin
                  result.status = cfb_pkg::ST_CLOSED;
               end else begin
                  result.status = cfb_pkg::ST_BLOCK;
               end
            end
            cfb_pkg::OP_POLL: begin
               if (ch_ok && nonempty_ff[ch]) begin
                  do_pop = 1'b1;
               end else begin
                  result.status = cfb_pkg::ST_EMPTY;
               end
            end
            cfb_pkg::OP_CLOSE: begin
               if (ch_ok) begin
                  closed_in[ch] = 1'b1;
               end
            end
            cfb_pkg::OP_SELECT: begin
               pop_ch      = sel_ch;
               result.chan = sel_ch;
               if (sel_any) begin
                  do_pop = 1'b1;
               end else begin
                  result.status = cfb_pkg::ST_EMPTY;
               end
            end
            default: begin
            end
         endcase
      end

      // Dequeue: issue the store read now, the word appears with the result strobe
      if (do_pop) begin
         result.pop          = 1'b1;
         mem_req.re          = 1'b1;
         mem_req.raddr       = {pop_ch, rd_ptr_ff[pop_ch]};
         rd_ptr_in[pop_ch]   = cfb_pkg::advance(rd_ptr_ff[pop_ch], cap_ff[pop_ch]);
         fill_in[pop_ch]     = fill_ff[pop_ch] - cfb_pkg::CNT_BITS'(1);
         nonempty_in[pop_ch] = fill_ff[pop_ch] != cfb_pkg::CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
            cap_ff[i]    <= cfb_pkg::CNT_BITS'(cfb_pkg::CHANNEL_DEPTH);
         end
         closed_ff   <= '0;
         nonempty_ff <= '0;
      end else begin
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         fill_ff     <= fill_in;
         cap_ff      <= cap_in;
         closed_ff   <= closed_in;
         nonempty_ff <= nonempty_in;
      end
   end

   a_nonempty_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      nonempty_ff[ch] == (fill_ff[ch] != '0))
      else $error("nonempty flag disagrees with fill count");

   a_fill_within_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff[ch] <= cap_ff[ch])
      else $error("fill count above channel capacity");

   a_send_fills: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |=> nonempty_ff[$past(ch)])
      else $error("stored word left channel marked empty");

   a_no_rw_conflict: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("store written and read by one operation");

endmodule

`default_nettype wire

// ===== design/closable_channel_fifo_bank_unit.sv =====
// Top level of the closable channel FIFO bank: channel control, word store, result stage.
// Depends on cfb_pkg, cfb_ctrl and cfb_ram.
`default_nettype none

// Eight ring-buffer channels of 32-bit words share one 128-word store. busy is always low:
// an operation can be started in every cycle, and its result comes with rsp_valid in the
// cycle after start was taken, since the result tag and the single store read of a dequeue
// are both registered. Results cannot be held off; sample them on the strobe.
// The store is not cleared at reset; no word is read before it was written.
module closable_channel_fifo_bank_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [2:0]  req_channel_id,
   input  wire logic [31:0] req_write_value,
   input  wire logic [4:0]  req_open_capacity,
   input  wire logic [7:0]  req_select_mask,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_read_value,
   output logic [2:0]       rsp_ready_channel
);

   cfb_pkg::mem_req_type          mem_req;
   cfb_pkg::result_type           result;
   logic                          accept;
   logic [cfb_pkg::WORD_BITS-1:0] rdata;

   logic                          rsp_valid_ff;
   cfb_pkg::status_type           status_ff;
   logic                          pop_ff;
   logic [cfb_pkg::CH_BITS-1:0]   chan_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   cfb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .opcode        (req_opcode),
      .channel_id    (req_channel_id),
      .write_value   (req_write_value),
      .open_capacity (req_open_capacity),
      .select_mask   (req_select_mask),
      .mem_req       (mem_req),
      .result        (result)
   );

   cfb_ram #(
      .WIDTH (cfb_pkg::WORD_BITS),
      .DEPTH (cfb_pkg::STORE_SIZE)
   ) u_store (
      .clock    (clock),
      .we       (mem_req.we),
      .waddr    (mem_req.waddr),
      .wdata    (mem_req.wdata),
      .re       (mem_req.re),
      .raddr    (mem_req.raddr),
      .rdata_ff (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result.valid;
      end
      status_ff <= result.status;
      pop_ff    <= result.pop;
      chan_ff   <= result.chan;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   // Drop the stale store word when nothing was dequeued
   assign rsp_read_value    = pop_ff ? rdata : '0;
   assign rsp_ready_channel = 3'(chan_ff);

   a_result_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept))
      else $error("result strobe without a started operation");

   a_pop_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pop_ff |-> status_ff == cfb_pkg::ST_OK)
      else $error("dequeued word reported with a failure status");

   a_empty_select_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pop_ff |-> rsp_read_value == '0)
      else $error("nonzero word without a dequeue");

endmodule

`default_nettype wire

// ===== tb/tb_closable_channel_fifo_bank_unit.sv =====
// Self-checking testbench for closable_channel_fifo_bank_unit: directed and random queue traffic.
// A behavioral copy of the channel bank predicts every response.
// Depends on cfb_pkg for the opcode and status codes.

module tb_closable_channel_fifo_bank_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int         MAX_GAP    = 17;
   localparam int         NUM_RANDOM = 1425;
   localparam int         CYCLE_LIMIT = 200000;

   typedef struct {
      cfb_pkg::status_type status;
      logic [31:0]         value;
      logic [2:0]          chan;
   } bank_response_type;

   // Channel bank behavior plus the queue of responses still owed by the block.
   class scoreboard_type;
      logic [31:0]       word_mem [cfb_pkg::NUM_CHANNELS][cfb_pkg::CHANNEL_DEPTH];
      int                rd_ptr [cfb_pkg::NUM_CHANNELS];
      int                wr_ptr [cfb_pkg::NUM_CHANNELS];
      int                fill [cfb_pkg::NUM_CHANNELS];
      int                depth_of [cfb_pkg::NUM_CHANNELS];
      bit                closed [cfb_pkg::NUM_CHANNELS];
      bank_response_type owed [$];
      int                errors;
      int                checked;
      int                ops_seen [8];
      int                status_seen [4];

      function new();
         for (int c = 0; c < cfb_pkg::NUM_CHANNELS; c++) begin
            rd_ptr[c]   = 0;
            wr_ptr[c]   = 0;
            fill[c]     = 0;
            depth_of[c] = cfb_pkg::CHANNEL_DEPTH;
            closed[c]   = 1'b0;
         end
         errors  = 0;
         checked = 0;
         foreach (ops_seen[i]) ops_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int wrap_ptr(int p, int depth);
         return (p + 1 >= depth) ? 0 : p + 1;
      endfunction

      function logic [31:0] dequeue(int c);
         logic [31:0] w;
         w = word_mem[c][rd_ptr[c]];
         rd_ptr[c] = wrap_ptr(rd_ptr[c], depth_of[c]);
         fill[c]--;
         return w;
      endfunction

      function void note_request(logic [2:0] op, logic [2:0] ch, logic [31:0] wv,
                                 logic [4:0] cap, logic [7:0] mask);
         bank_response_type r;
         int c;
         r.status = cfb_pkg::ST_OK;
         r.value  = '0;
         r.chan   = '0;
         c = int'(ch);
         ops_seen[op]++;
         case (op)
            cfb_pkg::OP_OPEN: begin
               rd_ptr[c]   = 0;
               wr_ptr[c]   = 0;
               fill[c]     = 0;
               depth_of[c] = (cap == 0 || int'(cap) > cfb_pkg::CHANNEL_DEPTH) ?
                             cfb_pkg::CHANNEL_DEPTH : int'(cap);
               closed[c]   = 1'b0;
            end
            cfb_pkg::OP_SEND: begin
               if (closed[c])
                  r.status = cfb_pkg::ST_CLOSED;
               else if (fill[c] >= depth_of[c])
                  r.status = cfb_pkg::ST_BLOCK;
               else begin
                  word_mem[c][wr_ptr[c]] = wv;
                  wr_ptr[c] = wrap_ptr(wr_ptr[c], depth_of[c]);
                  fill[c]++;
               end
            end
            cfb_pkg::OP_RECV: begin
               if (fill[c] > 0)
                  r.value = dequeue(c);
               else if (closed[c])
                  r.status = cfb_pkg::ST_CLOSED;
               else
                  r.status = cfb_pkg::ST_BLOCK;
            end
            cfb_pkg::OP_POLL: begin
               if (fill[c] > 0)
                  r.value = dequeue(c);
               else
                  r.status = cfb_pkg::ST_EMPTY;
            end
            cfb_pkg::OP_CLOSE: closed[c] = 1'b1;
            cfb_pkg::OP_SELECT: begin
               r.status = cfb_pkg::ST_EMPTY;
               for (int k = 0; k < cfb_pkg::NUM_CHANNELS; k++) begin
                  if (mask[k] && fill[k] > 0) begin
                     r.value  = dequeue(k);
                     r.chan   = k[2:0];
                     r.status = cfb_pkg::ST_OK;
                     break;
                  end
               end
            end
            default: ;
         endcase
         owed.push_back(r);
      endfunction

      function void check_response(logic [1:0] st, logic [31:0] value, logic [2:0] chan);
         bank_response_type r;
         if (owed.size() == 0) begin
            $display("%0t: unexpected response status %0d value %h channel %0d",
                     $time, st, value, chan);
            errors++;
            return;
         end
         r = owed.pop_front();
         checked++;
         status_seen[r.status]++;
         if (st !== r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, r.status, st);
            errors++;
         end
         if (value !== r.value) begin
            $display("%0t: read_value expected %h actual %h", $time, r.value, value);
            errors++;
         end
         if (chan !== r.chan) begin
            $display("%0t: ready_channel expected %0d actual %0d", $time, r.chan, chan);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_opcode;
   logic [2:0]  req_channel_id;
   logic [31:0] req_write_value;
   logic [4:0]  req_open_capacity;
   logic [7:0]  req_select_mask;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_read_value;
   logic [2:0]  rsp_ready_channel;

   scoreboard_type sb = new();
   int cycle_count = 0;
   int stretch_left = 0;
   bit stretch_busy_free = 1'b0;

   closable_channel_fifo_bank_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_channel_id    (req_channel_id),
      .req_write_value   (req_write_value),
      .req_open_capacity (req_open_capacity),
      .req_select_mask   (req_select_mask),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_ready_channel (rsp_ready_channel)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid)
         sb.check_response(rsp_status, rsp_read_value, rsp_ready_channel);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, sb.owed.size());
         $display("Verification failed");
         $finish;
      end
   end

   // Mix stretches of back-to-back words with stretches of random gaps.
   function automatic int next_gap();
      if (stretch_left == 0) begin
         stretch_left      = int'($urandom_range(10, 60));
         stretch_busy_free = ($urandom_range(0, 2) == 0);
      end
      stretch_left--;
      return stretch_busy_free ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   task automatic issue_word(input logic [2:0] op, input logic [2:0] ch,
                             input logic [31:0] wv, input logic [4:0] cap,
                             input logic [7:0] mask);
      int gap;
      gap = next_gap();
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start             = 1'b1;
      req_opcode        = op;
      req_channel_id    = ch;
      req_write_value   = wv;
      req_open_capacity = cap;
      req_select_mask   = mask;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(op, ch, wv, cap, mask);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      start = 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [2:0]  op;
      logic [2:0]  ch;
      logic [31:0] wv;
      logic [4:0]  cap;
      logic [7:0]  mask;
      int          pick;

      reset             = 1'b1;
      start             = 1'b0;
      req_opcode        = cfb_pkg::OP_OPEN;
      req_channel_id    = '0;
      req_write_value   = '0;
      req_open_capacity = '0;
      req_select_mask   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: FIFO order, blocking, closing, saturation, select priority, spare opcodes.
      issue_word(cfb_pkg::OP_SEND, 3'd0, 32'h7FFF_FFFF, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd0, 32'h8000_0000, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd0, 32'hFFFF_FFFF, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_RECV, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_POLL, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SELECT, 3'd0, 32'h0, 5'd0, 8'h01);
      issue_word(cfb_pkg::OP_RECV, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_POLL, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_CLOSE, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_RECV, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_POLL, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_OPEN, 3'd7, 32'h0, 5'd1, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd7, 32'hAAAA_AAAA, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd7, 32'h5555_5555, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_CLOSE, 3'd7, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd7, 32'h1234_5678, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_RECV, 3'd7, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_RECV, 3'd7, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_OPEN, 3'd2, 32'h0, 5'd31, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd5, 32'h1234_5678, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SEND, 3'd2, 32'h8765_4321, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_SELECT, 3'd0, 32'h0, 5'd0, 8'hFF);
      issue_word(cfb_pkg::OP_SELECT, 3'd7, 32'h0, 5'd0, 8'h20);
      issue_word(cfb_pkg::OP_SELECT, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(cfb_pkg::OP_OPEN, 3'd0, 32'h0, 5'd0, 8'h00);
      issue_word(OP_SPARE_6, 3'd3, 32'hDEAD_BEEF, 5'd9, 8'hFF);
      issue_word(OP_SPARE_7, 3'd5, 32'hFFFF_FFFF, 5'd31, 8'hFF);
      hold_until_drained();

      // Random: traffic leans on send and the dequeue paths so channels fill and drain.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n % 300 == 299)
            hold_until_drained();
         pick = int'($urandom_range(0, 99));
         if (pick < 38)      op = cfb_pkg::OP_SEND;
         else if (pick < 52) op = cfb_pkg::OP_RECV;
         else if (pick < 66) op = cfb_pkg::OP_POLL;
         else if (pick < 82) op = cfb_pkg::OP_SELECT;
         else if (pick < 91) op = cfb_pkg::OP_OPEN;
         else if (pick < 97) op = cfb_pkg::OP_CLOSE;
         else                op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
         ch = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 7))
            0:       wv = 32'h8000_0000;
            1:       wv = 32'h7FFF_FFFF;
            2:       wv = 32'hFFFF_FFFF;
            default: wv = $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       cap = 5'd0;
            1:       cap = 5'($urandom_range(1, 4));
            2:       cap = 5'($urandom_range(5, 16));
            default: cap = 5'($urandom_range(17, 31));
         endcase
         case ($urandom_range(0, 2))
            0:       mask = 8'hFF;
            1:       mask = 8'h01 << $urandom_range(0, 7);
            default: mask = 8'($urandom_range(0, 255));
         endcase
         issue_word(op, ch, wv, cap, mask);
      end
      hold_until_drained();
      repeat (4) @(posedge clock);

      $display("Run covered %0d requests: open %0d send %0d recv %0d poll %0d close %0d",
               sb.checked, sb.ops_seen[cfb_pkg::OP_OPEN], sb.ops_seen[cfb_pkg::OP_SEND],
               sb.ops_seen[cfb_pkg::OP_RECV], sb.ops_seen[cfb_pkg::OP_POLL],
               sb.ops_seen[cfb_pkg::OP_CLOSE]);
      $display("select %0d spare %0d; responses ok %0d block %0d closed %0d empty %0d",
               sb.ops_seen[cfb_pkg::OP_SELECT],
               sb.ops_seen[OP_SPARE_6] + sb.ops_seen[OP_SPARE_7],
               sb.status_seen[cfb_pkg::ST_OK], sb.status_seen[cfb_pkg::ST_BLOCK],
               sb.status_seen[cfb_pkg::ST_CLOSED], sb.status_seen[cfb_pkg::ST_EMPTY]);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
